// ===== rtl/core/page_framebuffer_engine_macros.svh =====
// assertion macros for the page frame buffer engine
`ifndef PAGE_FRAMEBUFFER_ENGINE_MACROS_SVH
`define PAGE_FRAMEBUFFER_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF
`define PFE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFE_ASSERT(lbl, clk, rstn, prop, msg)
`define PFE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/pfe_pkg.sv =====
// shared constants and codes of the page frame buffer engine
package pfe_pkg;

    localparam int PFE_WIDTH  = 128;
    localparam int PFE_HEIGHT = 64;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    localparam logic [1:0] COLOR_CLEAR = 2'd0;
    localparam logic [1:0] COLOR_SET   = 2'd1;

    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_RANGE = 2'd1;
    localparam logic [1:0] KIND_CMD   = 2'd2;
    localparam logic [1:0] KIND_DATA  = 2'd3;

    localparam logic [7:0] CMD_COL_LO = 8'h00;
    localparam logic [7:0] CMD_COL_HI = 8'h10;
    localparam logic [7:0] CMD_PAGE   = 8'hB0;

endpackage

// ===== rtl/core/page_framebuffer_engine.sv =====
// page organised monochrome frame buffer with pixel writes and refresh stream
//
// The frame store is one synchronous RAM of WIDTH*ceil(HEIGHT/8) bytes; byte
// (y/8)*WIDTH+x holds column x of page y/8, row y%8 in bit y%8. An in-range
// pixel request reads its store byte and, for a set or clear colour, writes
// it back; a flush request only reads. A pixel, flush or unused request is
// accepted with the store read, then finished once the result register is
// free; no new request is taken before that. A clear request sweeps the store
// one byte a cycle. After reset the same sweep runs first, with s_ready low.
// The result register lets a new request in while the previous result still
// waits on m_ready. Flush requests walk the refresh stream: per page the bytes
// 0x00, 0x10, 0xB0|page (kind command), then WIDTH data bytes; m_flush_done
// marks the last byte.
module page_framebuffer_engine #(
    parameter int WIDTH  = pfe_pkg::PFE_WIDTH,
    parameter int HEIGHT = pfe_pkg::PFE_HEIGHT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_operation,
    input  logic signed [8:0] s_px,
    input  logic signed [8:0] s_py,
    input  logic [1:0]        s_pixel_color,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [7:0]        m_out_byte,
    output logic              m_flush_done
);

    import pfe_pkg::*;

    `include "page_framebuffer_engine_macros.svh"

    localparam int PAGES    = (HEIGHT + 7) / 8;
    localparam int STORE    = WIDTH * PAGES;
    localparam int ADDR_W   = $clog2(STORE);
    localparam int POS_W    = $clog2(WIDTH + 3);
    localparam int POS_LAST = WIDTH + 2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FINISH
    } state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic                clr_report_reg;
    logic [1:0]          op_reg;
    logic                pix_ok_reg;
    logic [1:0]          color_reg;
    logic [2:0]          bit_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [2:0]          page_reg;
    logic [2:0]          page_next;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic                m_valid_reg;
    logic [1:0]          m_kind_reg;
    logic [7:0]          m_out_byte_reg;
    logic                m_flush_done_reg;

    logic [7:0]          mem [STORE];
    logic [7:0]          rd_data_reg;

    logic                accept;
    logic                out_free;
    logic                finish;
    logic                x_ok;
    logic                y_ok;
    logic [11:0]         pix_addr;
    logic [11:0]         flush_addr;
    logic [ADDR_W-1:0]   mem_raddr;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [7:0]          mem_wdata;
    logic [7:0]          bit_mask;
    logic [1:0]          kind_next;
    logic [7:0]          byte_next;
    logic                done_next;

    assign s_ready      = (state_reg == ST_IDLE);
    assign accept       = s_valid && s_ready;
    assign out_free     = !m_valid_reg || m_ready;
    assign finish       = (state_reg == ST_FINISH) && out_free;
    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_out_byte   = m_out_byte_reg;
    assign m_flush_done = m_flush_done_reg;

    // address of the request at the input
    assign x_ok       = !s_px[8] && (10'(s_px[7:0]) < 10'(WIDTH));
    assign y_ok       = !s_py[8] && (9'(s_py[7:0]) < 9'(HEIGHT));
    assign pix_addr   = 12'(s_py[5:3]) * 12'(WIDTH) + 12'(s_px[7:0]);
    assign flush_addr = 12'(page_reg) * 12'(WIDTH) + 12'(pos_reg) - 12'd3;
    assign mem_raddr  = (s_operation == OP_FLUSH) ? flush_addr[ADDR_W-1:0]
                                                  : pix_addr[ADDR_W-1:0];

    assign bit_mask = 8'h01 << bit_reg;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = rd_data_reg;
        if (state_reg == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = 8'h00;
        end else if (finish && op_reg == OP_PIXEL && pix_ok_reg) begin
            if (color_reg == COLOR_CLEAR) begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg & ~bit_mask;
            end else if (color_reg == COLOR_SET) begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg | bit_mask;
            end
        end
    end

    always_comb begin
        kind_next = KIND_DONE;
        byte_next = 8'h00;
        done_next = 1'b0;
        page_next = page_reg;
        pos_next  = pos_reg;
        case (op_reg)
            OP_PIXEL: begin
                kind_next = pix_ok_reg ? KIND_DONE : KIND_RANGE;
            end
            OP_FLUSH: begin
                case (pos_reg)
                    POS_W'(0): begin
                        kind_next = KIND_CMD;
                        byte_next = CMD_COL_LO;
                    end
                    POS_W'(1): begin
                        kind_next = KIND_CMD;
                        byte_next = CMD_COL_HI;
                    end
                    POS_W'(2): begin
                        kind_next = KIND_CMD;
                        byte_next = CMD_PAGE | {5'b0, page_reg};
                    end
                    default: begin
                        kind_next = KIND_DATA;
                        byte_next = rd_data_reg;
                    end
                endcase
                if (pos_reg == POS_W'(POS_LAST)) begin
                    pos_next = '0;
                    if (page_reg == 3'(PAGES - 1)) begin
                        page_next = 3'd0;
                        done_next = 1'b1;
                    end else begin
                        page_next = page_reg + 3'd1;
                    end
                end else begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
            default: begin
                kind_next = KIND_DONE;
            end
        endcase
    end

    // frame store
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            clr_report_reg   <= 1'b0;
            op_reg           <= OP_CLEAR;
            page_reg         <= 3'd0;
            pos_reg          <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && !finish) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    if (clr_cnt_reg == ADDR_W'(STORE - 1)) begin
                        clr_cnt_reg <= '0;
                        state_reg   <= clr_report_reg ? ST_FINISH : ST_IDLE;
                    end else begin
                        clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        op_reg     <= s_operation;
                        pix_ok_reg <= x_ok && y_ok;
                        color_reg  <= s_pixel_color;
                        bit_reg    <= s_py[2:0];
                        addr_reg   <= pix_addr[ADDR_W-1:0];
                        if (s_operation == OP_CLEAR) begin
                            clr_report_reg <= 1'b1;
                            state_reg      <= ST_CLEAR;
                        end else begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg      <= 1'b1;
                        m_kind_reg       <= kind_next;
                        m_out_byte_reg   <= byte_next;
                        m_flush_done_reg <= done_next;
                        page_reg         <= page_next;
                        pos_reg          <= pos_next;
                        state_reg        <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `PFE_ASSERT(a_one_in_flight, aclk, aresetn, accept |=> !s_ready, "request accepted while busy")
    `PFE_ASSERT(a_done_on_data, aclk, aresetn, (m_valid && m_flush_done) |-> (m_kind == KIND_DATA), "flush done without data byte")
    `PFE_ASSERT(a_write_window, aclk, aresetn, mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_FINISH), "store written outside clear or finish")
    `PFE_ASSERT(a_pos_range, aclk, aresetn, pos_reg <= POS_W'(POS_LAST), "refresh position beyond page end")

endmodule
